/* design/tsq_pkg.sv */
// ----------------------------------------------------------------------------
// Two-stack queue package
// Sizes, operation codes, result status codes and sequencer states shared by the queue core.
// ----------------------------------------------------------------------------
`default_nettype none

package tsq_pkg;

    // Entries per stack.
    localparam int DEPTH = 128;

    // Stack address and fill count widths; a count must hold DEPTH itself.
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int DATA_W = 32;

    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    // Operation codes carried on func.
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_XFER_RD,
        S_XFER_WR,
        S_POP_RD,
        S_POP_OUT
    } state_t;

endpackage : tsq_pkg

`default_nettype wire

/* design/two_stack_queue_core.sv */
// ----------------------------------------------------------------------------
// Two-stack queue core
// First-in first-out queue of 32-bit values built from an input stack and an
// output stack, each a memory of DEPTH entries with one write port and one
// registered read port.
// ----------------------------------------------------------------------------
// An operation is accepted when start is high and busy is low. Its result
// appears on value_out and status for exactly one cycle with done high; the
// receiver cannot stall it. An enqueue, or a dequeue on an empty queue, keeps
// busy low and returns its beat in the next cycle, so the next operation can
// follow at once. A dequeue from a non-empty output stack holds busy through
// the S_POP_RD and S_POP_OUT states while the registered memory read of the
// top entry completes, and its beat is registered in S_POP_OUT. A dequeue that
// finds the output stack empty first moves all input stack entries across,
// each with one read of the input stack memory in S_XFER_RD and one write of
// the output stack memory in S_XFER_WR, with busy held throughout. Each entry
// crosses only once.
// ----------------------------------------------------------------------------
`default_nettype none

module two_stack_queue_core
    import tsq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     func,
    input  wire logic signed [DATA_W-1:0] value_in,
    output logic                          done,
    output logic signed [DATA_W-1:0]      value_out,
    output logic [1:0]                    status
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  in_count_reg, in_count_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;

    logic              done_reg, done_next;
    logic [DATA_W-1:0] value_out_reg, value_out_next;
    status_t           status_reg, status_next;

    // Stack memories.
    logic [DATA_W-1:0] in_mem  [DEPTH];
    logic [DATA_W-1:0] out_mem [DEPTH];

    logic              in_we;
    logic [ADDR_W-1:0] in_waddr;
    logic [DATA_W-1:0] in_wdata;
    logic [ADDR_W-1:0] in_raddr;
    logic [DATA_W-1:0] in_rdata_reg;

    logic              out_we;
    logic [ADDR_W-1:0] out_waddr;
    logic [DATA_W-1:0] out_wdata;
    logic [ADDR_W-1:0] out_raddr;
    logic [DATA_W-1:0] out_rdata_reg;

    logic [CNT_W-1:0]  in_top;
    logic [CNT_W-1:0]  out_top;

    assign in_top  = in_count_reg - CNT_ONE;
    assign out_top = out_count_reg - CNT_ONE;

    always_ff @(posedge clk)
    begin
        if (in_we)
        begin
            in_mem[in_waddr] <= in_wdata;
        end
        in_rdata_reg <= in_mem[in_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (out_we)
        begin
            out_mem[out_waddr] <= out_wdata;
        end
        out_rdata_reg <= out_mem[out_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_count_reg  <= '0;
            out_count_reg <= '0;
            done_reg      <= 1'b0;
            status_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            in_count_reg  <= in_count_next;
            out_count_reg <= out_count_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_out_reg <= value_out_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && func == FUNC_DEQ)
                begin
                    if (out_count_reg != '0)
                    begin
                        state_next = S_POP_RD;
                    end
                    else if (in_count_reg != '0)
                    begin
                        state_next = S_XFER_RD;
                    end
                end
            end
            S_XFER_RD:
            begin
                state_next = S_XFER_WR;
            end
            S_XFER_WR:
            begin
                // The count was already lowered when this entry was read.
                if (in_count_reg == '0)
                begin
                    state_next = S_POP_RD;
                end
                else
                begin
                    state_next = S_XFER_RD;
                end
            end
            S_POP_RD:
            begin
                state_next = S_POP_OUT;
            end
            S_POP_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory controls, counts and result beat.
    always_comb
    begin
        in_count_next  = in_count_reg;
        out_count_next = out_count_reg;
        done_next      = 1'b0;
        value_out_next = value_out_reg;
        status_next    = status_reg;

        in_we     = 1'b0;
        in_waddr  = in_count_reg[ADDR_W-1:0];
        in_wdata  = value_in;
        in_raddr  = in_top[ADDR_W-1:0];
        out_we    = 1'b0;
        out_waddr = out_count_reg[ADDR_W-1:0];
        out_wdata = in_rdata_reg;
        out_raddr = out_top[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (func == FUNC_ENQ)
                    begin
                        done_next      = 1'b1;
                        value_out_next = '0;
                        if (in_count_reg == CNT_FULL)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            status_next   = ST_OK;
                            in_we         = 1'b1;
                            in_count_next = in_count_reg + CNT_ONE;
                        end
                    end
                    else if (out_count_reg == '0 && in_count_reg == '0)
                    begin
                        done_next      = 1'b1;
                        value_out_next = '1;
                        status_next    = ST_EMPTY;
                    end
                end
            end
            S_XFER_RD:
            begin
                in_count_next = in_top;
            end
            S_XFER_WR:
            begin
                out_we         = 1'b1;
                out_count_next = out_count_reg + CNT_ONE;
            end
            S_POP_RD:
            begin
                // The read of the top entry is issued here by default.
            end
            S_POP_OUT:
            begin
                out_count_next = out_top;
                done_next      = 1'b1;
                value_out_next = out_rdata_reg;
                status_next    = ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign value_out = value_out_reg;
    assign status    = status_reg;

endmodule : two_stack_queue_core

`default_nettype wire

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// Two-stack queue core testbench
// Drives enqueue and dequeue commands through the start/busy handshake and
// checks each done beat against a behavioral copy of the two-stack queue or
// a fixed table row's typed expectation. Stimulus: a small hand-picked table,
// then random mixed, filling and draining runs, most with random sender gaps.
// ----------------------------------------------------------------------------

module testbench;
    import tsq_pkg::*;

    localparam int RANDOM_OPS  = 1350;
    localparam int STALL_LIMIT = 4000;
    localparam int SHOWN_MAX   = 10;
    localparam int TABLE_ROWS  = 20;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        status_t           status;
    } beat_t;

    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] arg;
        logic              fixed;
        logic [DATA_W-1:0] want_value;
        status_t           want_status;
    } table_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     func;
    logic signed [DATA_W-1:0] value_in;
    logic                     done;
    logic signed [DATA_W-1:0] value_out;
    logic [1:0]               status;

    // Expectation typed into the table travels alongside the operation.
    logic                     row_fixed;
    logic [DATA_W-1:0]        row_value;
    status_t                  row_status;

    // Behavioral copy of the two stacks.
    logic [DATA_W-1:0] push_side [DEPTH];
    logic [DATA_W-1:0] pop_side  [DEPTH];
    logic [CNT_W-1:0]  push_fill = '0;
    logic [CNT_W-1:0]  pop_fill  = '0;

    beat_t pending_beats [$];

    int mismatches   = 0;
    int ops_sent     = 0;
    int beats_seen   = 0;
    int full_drops   = 0;
    int empty_pops   = 0;
    int refills      = 0;
    int idle_cycles  = 0;
    int burst_left   = 0;
    bit steady       = 1'b0;

    table_row_t op_table [TABLE_ROWS] = '{
        '{FUNC_DEQ, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_EMPTY},
        '{FUNC_ENQ, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
        '{FUNC_ENQ, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK},
        '{FUNC_ENQ, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
        '{FUNC_ENQ, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
        '{FUNC_DEQ, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_OK},
        '{FUNC_ENQ, 32'h1234_5678, 1'b1, 32'h0000_0000, ST_OK},
        '{FUNC_DEQ, 32'h0000_0000, 1'b1, 32'h8000_0000, ST_OK},
        '{FUNC_DEQ, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
        '{FUNC_DEQ, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_OK},
        '{FUNC_DEQ, 32'h0000_0000, 1'b1, 32'h1234_5678, ST_OK},
        '{FUNC_DEQ, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_EMPTY},
        '{FUNC_DEQ, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, ST_EMPTY},
        '{FUNC_ENQ, 32'hA5A5_A5A5, 1'b0, 32'h0000_0000, ST_OK},
        '{FUNC_ENQ, 32'h5A5A_5A5A, 1'b0, 32'h0000_0000, ST_OK},
        '{FUNC_DEQ, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{FUNC_ENQ, 32'h0000_0001, 1'b0, 32'h0000_0000, ST_OK},
        '{FUNC_DEQ, 32'hDEAD_BEEF, 1'b0, 32'h0000_0000, ST_OK},
        '{FUNC_DEQ, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{FUNC_DEQ, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK}
    };

    two_stack_queue_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .value_in  (value_in),
        .done      (done),
        .value_out (value_out),
        .status    (status)
    );

    always #5 clk = ~clk;

    // Applies one operation to the behavioral stacks and returns its beat.
    function automatic beat_t queue_op_result(logic op, logic [DATA_W-1:0] arg);
        beat_t res;
        res = '{value: '0, status: ST_OK};
        if (op == FUNC_ENQ)
        begin
            if (push_fill == CNT_FULL)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                push_side[push_fill[ADDR_W-1:0]] = arg;
                push_fill = push_fill + CNT_ONE;
            end
        end
        else
        begin
            if (pop_fill == '0 && push_fill != '0)
            begin
                refills++;
                // Moving the whole input stack across reverses its order.
                while (push_fill != '0 && pop_fill != CNT_FULL)
                begin
                    push_fill = push_fill - CNT_ONE;
                    pop_side[pop_fill[ADDR_W-1:0]] = push_side[push_fill[ADDR_W-1:0]];
                    pop_fill = pop_fill + CNT_ONE;
                end
            end
            if (pop_fill == '0)
            begin
                res.value  = '1;
                res.status = ST_EMPTY;
            end
            else
            begin
                pop_fill  = pop_fill - CNT_ONE;
                res.value = pop_side[pop_fill[ADDR_W-1:0]];
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, beat_t want);
        mismatches++;
        if (mismatches <= SHOWN_MAX)
            $display("%0t: %s: expected value %h status %0d, got value %h status %0d",
                     $time, what, want.value, want.status, value_out, status);
    endtask

    always @(posedge clk)
    begin : beat_check
        beat_t want;
        if (rst_n)
        begin
            if (done)
            begin
                beats_seen++;
                if (status == ST_FULL)
                    full_drops++;
                else if (status == ST_EMPTY)
                    empty_pops++;
                if (pending_beats.size() == 0)
                begin
                    report_mismatch("beat with nothing outstanding", '{'0, ST_OK});
                end
                else
                begin
                    want = pending_beats.pop_front();
                    if (value_out !== want.value || status !== want.status)
                        report_mismatch("beat mismatch", want);
                end
            end
            if (start && !busy)
            begin
                want = queue_op_result(func, value_in);
                if (row_fixed)
                    want = '{row_value, row_status};
                pending_beats.push_back(want);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Holds start high until the operation is taken at an edge with busy low.
    task automatic issue_op(logic op, logic [DATA_W-1:0] arg, logic fixed,
                            logic [DATA_W-1:0] want_value, status_t want_status);
        start      <= 1'b1;
        func       <= op;
        value_in   <= arg;
        row_fixed  <= fixed;
        row_value  <= want_value;
        row_status <= want_status;
        do
            @(posedge clk);
        while (busy);
        ops_sent++;
    endtask

    task automatic pace_sender();
        if (!steady)
        begin
            if (burst_left == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    task automatic issue_random(logic op);
        issue_op(op, pick_value(), 1'b0, '0, ST_OK);
        pace_sender();
    endtask

    task automatic pause_until_drained();
        start <= 1'b0;
        while (pending_beats.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic fill_run();
        repeat (DEPTH + $urandom_range(1, 6)) issue_random(FUNC_ENQ);
    endtask

    task automatic drain_run(int len);
        repeat (len) issue_random(FUNC_DEQ);
    endtask

    initial
    begin
        int kind;
        int len;
        int enq_pct;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        func       <= FUNC_ENQ;
        value_in   <= '0;
        row_fixed  <= 1'b0;
        row_value  <= '0;
        row_status <= ST_OK;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (op_table[i])
        begin
            issue_op(op_table[i].op, op_table[i].arg, op_table[i].fixed,
                     op_table[i].want_value, op_table[i].want_status);
            pace_sender();
        end
        pause_until_drained();

        // Reach a full input stack early, then empty everything out.
        fill_run();
        drain_run(2 * DEPTH + 4);
        while (ops_sent < TABLE_ROWS + RANDOM_OPS)
        begin
            kind   = $urandom_range(0, 19);
            steady = ($urandom_range(0, 3) == 0);
            if (kind < 12)
            begin
                len     = $urandom_range(10, 80);
                enq_pct = $urandom_range(15, 85);
                repeat (len)
                    issue_random(($urandom_range(1, 100) <= enq_pct) ? FUNC_ENQ : FUNC_DEQ);
            end
            else if (kind < 15)
            begin
                fill_run();
            end
            else if (kind < 18)
            begin
                drain_run($urandom_range(DEPTH / 2, 2 * DEPTH + 4));
            end
            else
            begin
                pause_until_drained();
            end
        end

        pause_until_drained();
        repeat (20) @(posedge clk);
        $display("Summary: %0d operations issued, %0d beats checked, %0d stack refills",
                 ops_sent, beats_seen, refills);
        $display("Summary: %0d enqueues dropped on a full stack, %0d dequeues on an empty queue",
                 full_drops, empty_pops);
        if (mismatches == 0 && pending_beats.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* two_stack_queue_core.f */
design/tsq_pkg.sv
design/two_stack_queue_core.sv
test/testbench.sv
